// ===== sv/calorimeter_ring_energy_sum_defines.svh =====
// Assertion macros for the ring energy sum block.
// Used by the top level only; expects clk and rst in scope at the point of use.
`ifndef CALORIMETER_RING_ENERGY_SUM_DEFINES_SVH
`define CALORIMETER_RING_ENERGY_SUM_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CRES_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring energy sum: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define CRES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring energy sum: next-cycle check failed");

`endif

// ===== sv/cres_pkg.sv =====
// Shared types, codes and constants for the ring energy sum block.
// No dependencies; every module file uses it by scoped names.
package cres_pkg;

  localparam int NUM_LAYERS_DEF = 32;
  localparam int NUM_CHIPS_DEF  = 32;

  localparam int SUM_W    = 32;
  localparam int RADIUS_W = 34;
  localparam int GAIN_W   = 24;
  localparam int POS_W    = 16;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 64;

  // request codes
  localparam logic [1:0] REQ_LOAD_GAIN   = 2'd0;
  localparam logic [1:0] REQ_LOAD_CENTRE = 2'd1;
  localparam logic [1:0] REQ_HIT         = 2'd2;
  localparam logic [1:0] REQ_READ        = 2'd3;

  // cell kinds that count
  localparam logic [2:0] CELL_FULL = 3'd0;
  localparam logic [2:0] CELL_PAD  = 3'd4;

  // raw energy selection
  localparam logic [1:0] ESEL_TOTAL = 2'd0;
  localparam logic [1:0] ESEL_HIGH  = 2'd1;
  localparam logic [1:0] ESEL_LOW   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ESEL   = 2'd0;
  localparam logic [1:0] REG_CORE   = 2'd1;
  localparam logic [1:0] REG_RING7  = 2'd2;
  localparam logic [1:0] REG_RING19 = 2'd3;

  localparam logic [RADIUS_W-1:0] CORE_RADIUS_RST   = 34'd3072;
  localparam logic [RADIUS_W-1:0] RING7_RADIUS_RST  = 34'd20406;
  localparam logic [RADIUS_W-1:0] RING19_RADIUS_RST = 34'd64365;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [4:0]              layer;
    logic [4:0]              chip;
    logic [2:0]              cell_type;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [15:0]      energy_total;
    logic signed [15:0]      energy_high;
    logic signed [15:0]      energy_low;
    logic [GAIN_W-1:0]       gain_reciprocal;
  } cmd_t;

  typedef struct packed {
    logic [4:0]       layer_out;
    logic [SUM_W-1:0] sum_core;
    logic [SUM_W-1:0] sum_ring7;
    logic [SUM_W-1:0] sum_ring19;
    logic [SUM_W-1:0] sum_layer;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] core;
    logic [SUM_W-1:0] ring7;
    logic [SUM_W-1:0] ring19;
    logic [SUM_W-1:0] total;
  } sums_t;

  typedef struct packed {
    logic [1:0]          esel;
    logic [RADIUS_W-1:0] core_r2;
    logic [RADIUS_W-1:0] ring7_r2;
    logic [RADIUS_W-1:0] ring19_r2;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic gain_wr;
    logic centre_wr;
  } lookup_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } sum_ctl_t;

  typedef struct packed {
    logic mul_en;
    logic sqr_en;
    logic cmp_en;
  } hit_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL,
    ST_SQR,
    ST_CMP,
    ST_ACC,
    ST_RET
  } state_t;

  // address width for a table of n entries, at least one bit
  function automatic int addr_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== sv/cres_cfg_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on cres_pkg for the register codes, reset values and cfg_t.
module cres_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cres_pkg::APB_AW-1:0] paddr,
  input  logic [cres_pkg::APB_DW-1:0] pwdata,
  output logic [cres_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output cres_pkg::cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[cres_pkg::APB_AW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.esel      <= cres_pkg::ESEL_TOTAL;
      cfg.core_r2   <= cres_pkg::CORE_RADIUS_RST;
      cfg.ring7_r2  <= cres_pkg::RING7_RADIUS_RST;
      cfg.ring19_r2 <= cres_pkg::RING19_RADIUS_RST;
    end else if (wr) begin
      case (idx)
        cres_pkg::REG_ESEL:   cfg.esel      <= pwdata[1:0];
        cres_pkg::REG_CORE:   cfg.core_r2   <= pwdata[cres_pkg::RADIUS_W-1:0];
        cres_pkg::REG_RING7:  cfg.ring7_r2  <= pwdata[cres_pkg::RADIUS_W-1:0];
        cres_pkg::REG_RING19: cfg.ring19_r2 <= pwdata[cres_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cres_pkg::REG_ESEL:   prdata = cres_pkg::APB_DW'(cfg.esel);
      cres_pkg::REG_CORE:   prdata = cres_pkg::APB_DW'(cfg.core_r2);
      cres_pkg::REG_RING7:  prdata = cres_pkg::APB_DW'(cfg.ring7_r2);
      cres_pkg::REG_RING19: prdata = cres_pkg::APB_DW'(cfg.ring19_r2);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/cres_lookup_mem.sv =====
// Gain and layer centre memories with registered reads.
// Depends on cres_pkg for widths, lookup_ctl_t and addr_w.
module cres_lookup_mem #(
  parameter int NUM_LAYERS = cres_pkg::NUM_LAYERS_DEF,
  parameter int NUM_CHIPS  = cres_pkg::NUM_CHIPS_DEF
) (
  input  logic                                        clk,
  input  cres_pkg::lookup_ctl_t                       ctl,
  input  logic [cres_pkg::addr_w(NUM_CHIPS)-1:0]      chip_addr,
  input  logic [cres_pkg::addr_w(NUM_LAYERS)-1:0]     layer_addr,
  input  logic [cres_pkg::GAIN_W-1:0]                 gain_wdata,
  input  logic signed [cres_pkg::POS_W-1:0]           cx_wdata,
  input  logic signed [cres_pkg::POS_W-1:0]           cy_wdata,
  output logic [cres_pkg::GAIN_W-1:0]                 gain_rdata,
  output logic signed [cres_pkg::POS_W-1:0]           cx_rdata,
  output logic signed [cres_pkg::POS_W-1:0]           cy_rdata
);

  logic [cres_pkg::GAIN_W-1:0]  gain_mem   [NUM_CHIPS];
  logic [2*cres_pkg::POS_W-1:0] centre_mem [NUM_LAYERS];

  always_ff @(posedge clk) begin
    if (ctl.gain_wr) begin
      gain_mem[chip_addr] <= gain_wdata;
    end
    if (ctl.rd_en) begin
      gain_rdata <= gain_mem[chip_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.centre_wr) begin
      centre_mem[layer_addr] <= {cx_wdata, cy_wdata};
    end
    if (ctl.rd_en) begin
      {cx_rdata, cy_rdata} <= centre_mem[layer_addr];
    end
  end

endmodule

// ===== sv/cres_sum_mem.sv =====
// Per-layer sums memory with a valid bit per layer; an invalid layer reads as zero.
// Depends on cres_pkg for sums_t, sum_ctl_t and addr_w.
module cres_sum_mem #(
  parameter int NUM_LAYERS = cres_pkg::NUM_LAYERS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cres_pkg::sum_ctl_t                      ctl,
  input  logic [cres_pkg::addr_w(NUM_LAYERS)-1:0] addr,
  input  cres_pkg::sums_t                         wdata,
  output cres_pkg::sums_t                         rdata
);

  cres_pkg::sums_t        mem [NUM_LAYERS];
  logic [NUM_LAYERS-1:0]  valid;
  cres_pkg::sums_t        raw_q;
  logic                   valid_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      raw_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[addr] <= 1'b1;
      end else if (ctl.clr_en) begin
        valid[addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        valid_q <= valid[addr];
      end
    end
  end

  assign rdata = valid_q ? raw_q : '0;

endmodule

// ===== sv/cres_hit_math.sv =====
// Hit arithmetic: gain multiply, distance squares, threshold compares, saturating update.
// Depends on cres_pkg for cmd_t, cfg_t, sums_t, hit_ctl_t and the codes.
module cres_hit_math #(
  parameter int NUM_CHIPS = cres_pkg::NUM_CHIPS_DEF
) (
  input  logic                              clk,
  input  cres_pkg::hit_ctl_t                ctl,
  input  cres_pkg::cmd_t                    item,
  input  cres_pkg::cfg_t                    cfg,
  input  logic [cres_pkg::GAIN_W-1:0]       gain,
  input  logic signed [cres_pkg::POS_W-1:0] cx,
  input  logic signed [cres_pkg::POS_W-1:0] cy,
  input  cres_pkg::sums_t                   sums_in,
  output cres_pkg::sums_t                   sums_out,
  output logic                              hit_ok
);

  localparam int PROD_W = 16 + cres_pkg::GAIN_W + 1;
  localparam int P9_W   = PROD_W + 4;
  localparam int SQ_W   = 2 * cres_pkg::POS_W;

  function automatic logic [cres_pkg::SUM_W-1:0] sat_add(
    input logic [cres_pkg::SUM_W-1:0] a,
    input logic [cres_pkg::SUM_W-1:0] b
  );
    logic [cres_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[cres_pkg::SUM_W] ? '1 : s[cres_pkg::SUM_W-1:0];
  endfunction

  logic signed [15:0]               raw;
  logic                             sel_ok;
  logic signed [cres_pkg::GAIN_W:0] gain_s;
  logic signed [cres_pkg::POS_W:0]  dx_s;
  logic signed [cres_pkg::POS_W:0]  dy_s;
  logic signed [cres_pkg::POS_W:0]  dx_a;
  logic signed [cres_pkg::POS_W:0]  dy_a;
  logic [P9_W-1:0]                  p_ext;
  logic [P9_W-1:0]                  p9;
  logic [SQ_W:0]                    d2;

  // multiply stage
  logic signed [PROD_W-1:0]         prod;
  logic [cres_pkg::POS_W-1:0]       dx;
  logic [cres_pkg::POS_W-1:0]       dy;
  logic                             ok_mul;
  logic                             pad_mul;
  // square stage
  logic [SQ_W-1:0]                  dx2;
  logic [SQ_W-1:0]                  dy2;
  logic [cres_pkg::SUM_W-1:0]       energy;
  logic                             ok_sqr;
  // compare stage
  logic                             in_core;
  logic                             in_ring7;
  logic                             in_ring19;

  always_comb begin
    sel_ok = 1'b1;
    case (cfg.esel)
      cres_pkg::ESEL_TOTAL: raw = item.energy_total;
      cres_pkg::ESEL_HIGH:  raw = item.energy_high;
      cres_pkg::ESEL_LOW:   raw = item.energy_low;
      default: begin
        raw    = '0;
        sel_ok = 1'b0;
      end
    endcase
  end

  assign gain_s = $signed({1'b0, gain});
  assign dx_s   = $signed({item.pos_x[cres_pkg::POS_W-1], item.pos_x})
                - $signed({cx[cres_pkg::POS_W-1], cx});
  assign dy_s   = $signed({item.pos_y[cres_pkg::POS_W-1], item.pos_y})
                - $signed({cy[cres_pkg::POS_W-1], cy});
  assign dx_a   = dx_s[cres_pkg::POS_W] ? -dx_s : dx_s;
  assign dy_a   = dy_s[cres_pkg::POS_W] ? -dy_s : dy_s;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod    <= PROD_W'(raw) * PROD_W'(gain_s);
      dx      <= dx_a[cres_pkg::POS_W-1:0];
      dy      <= dy_a[cres_pkg::POS_W-1:0];
      ok_mul  <= sel_ok && (int'(item.chip) < NUM_CHIPS)
              && (item.cell_type == cres_pkg::CELL_FULL
               || item.cell_type == cres_pkg::CELL_PAD);
      pad_mul <= (item.cell_type == cres_pkg::CELL_PAD);
    end
  end

  // times nine as shift and add; only used when the product is positive
  assign p_ext = {{(P9_W-PROD_W){1'b0}}, prod};
  assign p9    = (p_ext << 3) + p_ext;

  always_ff @(posedge clk) begin
    if (ctl.sqr_en) begin
      dx2    <= SQ_W'(dx) * SQ_W'(dx);
      dy2    <= SQ_W'(dy) * SQ_W'(dy);
      energy <= pad_mul ? p9[cres_pkg::SUM_W+10:11] : p_ext[cres_pkg::SUM_W+7:8];
      ok_sqr <= ok_mul && !prod[PROD_W-1] && (prod != '0);
    end
  end

  assign d2 = {1'b0, dx2} + {1'b0, dy2};

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      in_core   <= cres_pkg::RADIUS_W'(d2) < cfg.core_r2;
      in_ring7  <= cres_pkg::RADIUS_W'(d2) < cfg.ring7_r2;
      in_ring19 <= cres_pkg::RADIUS_W'(d2) < cfg.ring19_r2;
      hit_ok    <= ok_sqr;
    end
  end

  always_comb begin
    sums_out.core   = in_core   ? sat_add(sums_in.core, energy)   : sums_in.core;
    sums_out.ring7  = in_ring7  ? sat_add(sums_in.ring7, energy)  : sums_in.ring7;
    sums_out.ring19 = in_ring19 ? sat_add(sums_in.ring19, energy) : sums_in.ring19;
    sums_out.total  = sat_add(sums_in.total, energy);
  end

endmodule

// ===== sv/calorimeter_ring_energy_sum.sv =====
// Top level of the ring energy sum block: request sequencer, memories and datapath.
// Depends on cres_pkg, the defines header and the cres_* submodules.
//
// Usage: present a request on cmd with start high; it is taken at a clock edge where
// busy is low. One request is worked at a time, and busy stays high until its
// write-back is done, so a later request on the same layer always sees the result
// of an earlier one. A gain or centre load writes its memory in the fetch state.
// A hit fetches from the gain, centre and sums memories, multiplies raw energy by
// the gain, squares the distances, compares against the three radius limits, then
// writes the saturated sums back to the sums memory. A read fetches, then in its
// return state clears the layer and registers the sums onto result, where they go
// out with result_valid high for exactly one cycle. The receiver cannot stall the
// result beat; capture it when result_valid is high. Hits with a layer or chip
// beyond the configured counts, cell types other than full cell and calibration
// pad, non-positive energies or energy select 3, reads or centre loads with a
// layer beyond, and gain loads with a chip beyond change nothing and give no
// result. The sums come up cleared at reset through a valid bit per layer, so no
// clearing pass is needed and start is honored right away.
// Write configuration only while busy is low.
`include "calorimeter_ring_energy_sum_defines.svh"

module calorimeter_ring_energy_sum #(
  parameter int NUM_LAYERS = cres_pkg::NUM_LAYERS_DEF,
  parameter int NUM_CHIPS  = cres_pkg::NUM_CHIPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  cres_pkg::cmd_t              cmd,
  // result channel
  output logic                        result_valid,
  output cres_pkg::result_t           result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cres_pkg::APB_AW-1:0] paddr,
  input  logic [cres_pkg::APB_DW-1:0] pwdata,
  output logic [cres_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int LayerAw = cres_pkg::addr_w(NUM_LAYERS);
  localparam int ChipAw  = cres_pkg::addr_w(NUM_CHIPS);

  cres_pkg::state_t      state;
  cres_pkg::state_t      state_next;
  cres_pkg::cmd_t        item;
  cres_pkg::cfg_t        cfg;
  cres_pkg::lookup_ctl_t lk_ctl;
  cres_pkg::sum_ctl_t    sum_ctl;
  cres_pkg::hit_ctl_t    hit_ctl;

  logic                                layer_ok;
  logic                                chip_ok;
  logic [LayerAw-1:0]                  layer_idx;
  logic [ChipAw-1:0]                   chip_idx;
  logic [cres_pkg::GAIN_W-1:0]         gain_rd;
  logic signed [cres_pkg::POS_W-1:0]   cx_rd;
  logic signed [cres_pkg::POS_W-1:0]   cy_rd;
  cres_pkg::sums_t                     sums_rd;
  cres_pkg::sums_t                     sums_wr;
  logic                                hit_ok;

  assign layer_ok  = int'(item.layer) < NUM_LAYERS;
  assign chip_ok   = int'(item.chip) < NUM_CHIPS;
  assign layer_idx = LayerAw'(item.layer);
  assign chip_idx  = ChipAw'(item.chip);

  // Hold the request for the whole of its work.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cres_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: fetch every request, then branch on its kind.
  always_comb begin
    state_next = state;
    case (state)
      cres_pkg::ST_IDLE: begin
        if (start) begin
          state_next = cres_pkg::ST_FETCH;
        end
      end
      cres_pkg::ST_FETCH: begin
        if (layer_ok && item.req_type == cres_pkg::REQ_HIT) begin
          state_next = cres_pkg::ST_MUL;
        end else if (layer_ok && item.req_type == cres_pkg::REQ_READ) begin
          state_next = cres_pkg::ST_RET;
        end else begin
          state_next = cres_pkg::ST_IDLE;
        end
      end
      cres_pkg::ST_MUL: state_next = cres_pkg::ST_SQR;
      cres_pkg::ST_SQR: state_next = cres_pkg::ST_CMP;
      cres_pkg::ST_CMP: state_next = cres_pkg::ST_ACC;
      cres_pkg::ST_ACC: state_next = cres_pkg::ST_IDLE;
      cres_pkg::ST_RET: state_next = cres_pkg::ST_IDLE;
      default:          state_next = cres_pkg::ST_IDLE;
    endcase
  end

  // Per-state strobes to the memories and the datapath.
  always_comb begin
    busy    = 1'b1;
    lk_ctl  = '0;
    sum_ctl = '0;
    hit_ctl = '0;
    case (state)
      cres_pkg::ST_IDLE: busy = 1'b0;
      cres_pkg::ST_FETCH: begin
        lk_ctl.rd_en     = 1'b1;
        sum_ctl.rd_en    = 1'b1;
        lk_ctl.gain_wr   = chip_ok && item.req_type == cres_pkg::REQ_LOAD_GAIN;
        lk_ctl.centre_wr = layer_ok && item.req_type == cres_pkg::REQ_LOAD_CENTRE;
      end
      cres_pkg::ST_MUL: hit_ctl.mul_en = 1'b1;
      cres_pkg::ST_SQR: hit_ctl.sqr_en = 1'b1;
      cres_pkg::ST_CMP: hit_ctl.cmp_en = 1'b1;
      cres_pkg::ST_ACC: sum_ctl.wr_en  = hit_ok;
      cres_pkg::ST_RET: sum_ctl.clr_en = 1'b1;
      default: ;
    endcase
  end

  // Result beat: in the cycle after the read's return state, never stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == cres_pkg::ST_RET);
    end
  end

  always_ff @(posedge clk) begin
    if (state == cres_pkg::ST_RET) begin
      result.layer_out  <= item.layer;
      result.sum_core   <= sums_rd.core;
      result.sum_ring7  <= sums_rd.ring7;
      result.sum_ring19 <= sums_rd.ring19;
      result.sum_layer  <= sums_rd.total;
    end
  end

  cres_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cres_lookup_mem #(
    .NUM_LAYERS (NUM_LAYERS),
    .NUM_CHIPS  (NUM_CHIPS)
  ) u_lookup (
    .clk        (clk),
    .ctl        (lk_ctl),
    .chip_addr  (chip_idx),
    .layer_addr (layer_idx),
    .gain_wdata (item.gain_reciprocal),
    .cx_wdata   (item.pos_x),
    .cy_wdata   (item.pos_y),
    .gain_rdata (gain_rd),
    .cx_rdata   (cx_rd),
    .cy_rdata   (cy_rd)
  );

  cres_sum_mem #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_sums (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sum_ctl),
    .addr  (layer_idx),
    .wdata (sums_wr),
    .rdata (sums_rd)
  );

  cres_hit_math #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_math (
    .clk      (clk),
    .ctl      (hit_ctl),
    .item     (item),
    .cfg      (cfg),
    .gain     (gain_rd),
    .cx       (cx_rd),
    .cy       (cy_rd),
    .sums_in  (sums_rd),
    .sums_out (sums_wr),
    .hit_ok   (hit_ok)
  );

  // An accepted beat always makes the block busy on the next cycle.
  `CRES_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result beat comes only from a read's return state.
  `CRES_ASSERT_IMPL(a_result_src, result_valid, $past(state == cres_pkg::ST_RET))
  // One result beat per read, never two in a row.
  `CRES_ASSERT_NEXT(a_result_pulse, result_valid, !result_valid)

endmodule
